[hdl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and character helpers of the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] PCT_CHAR         = 8'h25;
    localparam logic [3:0] HEX_ALPHA_OFFSET = 4'd10;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam int unsigned GROUP_MAX = 3;

    typedef struct packed {
        logic [1:0]       count;
        logic [2:0][7:0]  bytes;
        logic             last;
    } upd_group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = c[3:0] + (HEX_ALPHA_OFFSET - 4'd1);
        end
        return v;
    endfunction

endpackage

[hdl/upd_stream_if.sv]
// ----------------------------------------------------------------------------
// upd_stream_if
// Valid/ready byte stream with an end-of-string flag.
// ----------------------------------------------------------------------------
interface upd_stream_if;

    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);

endinterface

[hdl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw characters, tracks the escape phase and builds the group of
// up to three decoded bytes that each character produces.
// ----------------------------------------------------------------------------
module upd_front
    import upd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    upd_stream_if.sink     in_ch,
    input  logic           q_full,
    output logic           push,
    output upd_group_t     push_group
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] first_digit_reg;
    logic [7:0] first_digit_next;
    logic       accept;
    upd_group_t grp;

    function automatic upd_group_t append(input upd_group_t g, input logic [7:0] x);
        upd_group_t r;
        r = g;
        if (r.count != 2'(GROUP_MAX))
        begin
            r.bytes[r.count] = x;
            r.count          = r.count + 2'd1;
        end
        return r;
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [7:0] c;
        logic       hex;
        c                = in_ch.data;
        hex              = is_hex(c);
        grp              = '0;
        phase_next       = PH_IDLE;
        first_digit_next = first_digit_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (hex)
                begin
                    first_digit_next = c;
                    phase_next       = PH_DIGIT;
                end
                else
                begin
                    grp = append(grp, PCT_CHAR);
                    if (c == PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        grp = append(grp, c);
                    end
                end
            end
            PH_DIGIT:
            begin
                if (hex)
                begin
                    grp = append(grp, {hex_val(first_digit_reg), hex_val(c)});
                end
                else
                begin
                    grp = append(grp, PCT_CHAR);
                    grp = append(grp, first_digit_reg);
                    if (c == PCT_CHAR)
                    begin
                        phase_next = PH_PCT;
                    end
                    else
                    begin
                        grp = append(grp, c);
                    end
                end
            end
            default:
            begin
                if (c == PCT_CHAR)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    grp = append(grp, c);
                end
            end
        endcase
        if (in_ch.last)
        begin
            if (phase_next == PH_PCT)
            begin
                grp = append(grp, PCT_CHAR);
            end
            else if (phase_next == PH_DIGIT)
            begin
                grp = append(grp, PCT_CHAR);
                grp = append(grp, first_digit_next);
            end
            phase_next = PH_IDLE;
            grp.last   = 1'b1;
        end
    end

    assign push       = accept && (grp.count != 2'd0);
    assign push_group = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            first_digit_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            first_digit_reg <= first_digit_next;
        end
    end

    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last) |-> (push && push_group.last))
        else $error("end of string produced no flagged group");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last) |=> (phase_reg == PH_IDLE))
        else $error("escape still pending after end of string");

endmodule

[hdl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Short queue of decoded byte groups between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue
    import upd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  upd_group_t push_group,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output upd_group_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    upd_group_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("group pushed into a full queue");

endmodule

[hdl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Sends the bytes of the queued groups one at a time and flags the final
// byte of a string.
// ----------------------------------------------------------------------------
module upd_back
    import upd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  upd_group_t  head,
    output logic        pop,
    upd_stream_if.source out_ch
);

    logic [1:0] idx_reg;
    logic       final_byte;
    logic       accept;

    assign final_byte   = (idx_reg == head.count - 2'd1);
    assign out_ch.valid = !empty;
    assign out_ch.data  = head.bytes[idx_reg];
    assign out_ch.last  = head.last && final_byte;
    assign accept       = out_ch.valid && out_ch.ready;
    assign pop          = accept && final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (accept)
        begin
            idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (idx_reg < head.count))
        else $error("byte index beyond the current group");

endmodule

[hdl/url_percent_decoder_top.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming percent decoder: front classifier, group queue, byte sender.
//
//   Channel   Dir   Payload               Accepted when
//   in_ch     in    data[7:0], last       valid && ready
//   out_ch    out   data[7:0], last       valid && ready
//
// One input character is taken per cycle while the group queue has room.
// Each character yields zero to three output bytes, sent one per cycle while
// the output side is ready, through the single output port.
// A character's group is registered in the queue before its bytes are sent.
// Reset clears the escape phase, queue pointers and the byte index.
// Either side may stall freely; the queue absorbs QUEUE_DEPTH groups.
// ----------------------------------------------------------------------------
module url_percent_decoder_top
    import upd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    upd_stream_if.sink   in_ch,
    upd_stream_if.source out_ch
);

    logic       push;
    upd_group_t push_group;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    upd_group_t head;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_full     (q_full),
        .push       (push),
        .push_group (push_group)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    upd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
